[src/mmt_pkg.sv]
// Shared types, token kind codes and helpers of the longest-match tokenizer.
`default_nettype none
package mmt_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] line;
		logic [15:0] start_offset;
		logic [16:0] length;
		logic        error;
		logic        last;
	} result_t;

	// Results one word causes, in order; vld1 only with vld0.
	typedef struct packed {
		logic    vld0;
		logic    vld1;
		result_t res0;
		result_t res1;
	} push_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUM,
		MODE_ASSIGN,
		MODE_BANG
	} scan_mode_t;

	localparam logic [4:0] K_RETURN = 5'd0;
	localparam logic [4:0] K_INT    = 5'd1;
	localparam logic [4:0] K_CHAR   = 5'd2;
	localparam logic [4:0] K_VOID   = 5'd3;
	localparam logic [4:0] K_IF     = 5'd4;
	localparam logic [4:0] K_NUMBER = 5'd5;
	localparam logic [4:0] K_ID     = 5'd6;
	localparam logic [4:0] K_LPAREN = 5'd7;
	localparam logic [4:0] K_RPAREN = 5'd8;
	localparam logic [4:0] K_LBRACE = 5'd9;
	localparam logic [4:0] K_RBRACE = 5'd10;
	localparam logic [4:0] K_COMMA  = 5'd11;
	localparam logic [4:0] K_PLUS   = 5'd12;
	localparam logic [4:0] K_MINUS  = 5'd13;
	localparam logic [4:0] K_STAR   = 5'd14;
	localparam logic [4:0] K_SLASH  = 5'd15;
	localparam logic [4:0] K_ASSIGN = 5'd16;
	localparam logic [4:0] K_EQ     = 5'd17;
	localparam logic [4:0] K_NE     = 5'd18;
	localparam logic [4:0] K_LT     = 5'd19;
	localparam logic [4:0] K_GT     = 5'd20;
	localparam logic [4:0] K_SEMI   = 5'd21;
	localparam logic [4:0] K_NONE   = 5'd0;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

	function automatic result_t mk_res(input logic [4:0] kind, input logic [15:0] line,
			input logic [15:0] start, input logic [16:0] len, input logic err,
			input logic last);
		result_t r;
		r.kind         = kind;
		r.line         = line;
		r.start_offset = start;
		r.length       = len;
		r.error        = err;
		r.last         = last;
		return r;
	endfunction

endpackage
`default_nettype wire

[src/mmt_scan.sv]
// Scanner state and the single-pass decision logic for one text word.
`default_nettype none
module mmt_scan import mmt_pkg::*; #(
	parameter int unsigned MAX_TEXT = 65536
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     fire,
	input  wire in_item_t item,
	output push_t         push
);

	localparam int unsigned POS_CAP_INT = (MAX_TEXT > 131071) ? 131071 : MAX_TEXT;
	localparam logic [16:0] POS_CAP = 17'(POS_CAP_INT);

	scan_mode_t  mode_q, mode_n;
	logic [47:0] prefix_q, prefix_n;
	logic [16:0] run_q, run_n;
	logic [15:0] tstart_q, tstart_n;
	logic [16:0] pos_q, pos_n;
	logic [15:0] line_q, line_n;
	logic        halted_q, halted_n;

	logic [7:0]  c;
	logic        lower, digit, space_ch;
	logic [15:0] cur_off;
	logic [16:0] pos_adv;
	logic        fvld, svld;
	result_t     fres, sres, fl_res;
	logic        fl_vld;
	logic [4:0]  pk;
	logic        pk_ok;

	function automatic logic [4:0] word_kind(input logic [16:0] run, input logic [47:0] pre);
		logic [4:0] k;
		k = K_ID;
		if (run == 17'd6 && pre == 48'h72657475726E)
			k = K_RETURN;
		else if (run == 17'd3 && pre == 48'h696E74)
			k = K_INT;
		else if (run == 17'd4 && pre == 48'h63686172)
			k = K_CHAR;
		else if (run == 17'd4 && pre == 48'h766F6964)
			k = K_VOID;
		else if (run == 17'd2 && pre == 48'h6966)
			k = K_IF;
		return k;
	endfunction

	always_comb begin
		pk_ok = 1'b1;
		case (c)
			8'h28: pk = K_LPAREN;
			8'h29: pk = K_RPAREN;
			8'h7B: pk = K_LBRACE;
			8'h7D: pk = K_RBRACE;
			8'h2C: pk = K_COMMA;
			8'h2B: pk = K_PLUS;
			8'h2D: pk = K_MINUS;
			8'h2A: pk = K_STAR;
			8'h2F: pk = K_SLASH;
			8'h3C: pk = K_LT;
			8'h3E: pk = K_GT;
			8'h3B: pk = K_SEMI;
			default: begin
				pk    = K_NONE;
				pk_ok = 1'b0;
			end
		endcase
	end

	assign c        = item.ch;
	assign lower    = (c >= 8'h61) && (c <= 8'h7A);
	assign digit    = (c >= 8'h30) && (c <= 8'h39);
	assign space_ch = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	assign cur_off  = (pos_q > 17'd65535) ? 16'hFFFF : pos_q[15:0];
	assign pos_adv  = (pos_q < POS_CAP) ? pos_q + 17'd1 : pos_q;

	// Pending token as it stands before this word.
	always_comb begin
		fl_vld = 1'b1;
		case (mode_q)
			MODE_WORD:   fl_res = mk_res(word_kind(run_q, prefix_q), line_q, tstart_q, run_q,
					1'b0, 1'b0);
			MODE_NUM:    fl_res = mk_res(K_NUMBER, line_q, tstart_q, run_q, 1'b0, 1'b0);
			MODE_ASSIGN: fl_res = mk_res(K_ASSIGN, line_q, tstart_q, 17'd1, 1'b0, 1'b0);
			MODE_BANG:   fl_res = mk_res(K_NONE, line_q, tstart_q, 17'd1, 1'b1, 1'b0);
			default: begin
				fl_res = mk_res(K_NONE, line_q, tstart_q, 17'd0, 1'b0, 1'b0);
				fl_vld = 1'b0;
			end
		endcase
	end

	always_comb begin
		mode_n   = mode_q;
		prefix_n = prefix_q;
		run_n    = run_q;
		tstart_n = tstart_q;
		pos_n    = pos_q;
		line_n   = line_q;
		halted_n = halted_q;
		fvld     = 1'b0;
		svld     = 1'b0;
		fres     = fl_res;
		sres     = mk_res(K_NONE, line_q, cur_off, 17'd1, 1'b1, 1'b0);
		if (fire) begin
			if (item.end_of_text) begin
				fvld     = fl_vld && !halted_q;
				svld     = 1'b1;
				sres     = mk_res(K_NONE, line_q, cur_off, 17'd0, 1'b0, 1'b1);
				mode_n   = MODE_IDLE;
				prefix_n = '0;
				run_n    = '0;
				tstart_n = '0;
				pos_n    = '0;
				line_n   = 16'd1;
				halted_n = 1'b0;
			end else if (halted_q) begin
				// drop text until end of text
			end else if ((mode_q == MODE_WORD && lower) || (mode_q == MODE_NUM && digit)) begin
				if (mode_q == MODE_WORD && run_q < 17'd6)
					prefix_n = {prefix_q[39:0], c};
				if (run_q < 17'd65536)
					run_n = run_q + 17'd1;
				pos_n = pos_adv;
			end else if ((mode_q == MODE_ASSIGN || mode_q == MODE_BANG) && c == 8'h3D) begin
				fvld   = 1'b1;
				fres   = mk_res((mode_q == MODE_ASSIGN) ? K_EQ : K_NE, line_q, tstart_q,
						17'd2, 1'b0, 1'b0);
				mode_n = MODE_IDLE;
				pos_n  = pos_adv;
			end else begin
				fvld   = fl_vld;
				mode_n = MODE_IDLE;
				pos_n  = pos_adv;
				if (mode_q == MODE_BANG) begin
					// lone bang: the byte after it and all text up to end of text are dropped
					halted_n = 1'b1;
				end else if (space_ch) begin
					if (c == 8'h0A && line_q < 16'hFFFF)
						line_n = line_q + 16'd1;
				end else if (lower || digit) begin
					mode_n   = lower ? MODE_WORD : MODE_NUM;
					tstart_n = cur_off;
					run_n    = 17'd1;
					prefix_n = {40'd0, c};
				end else if (c == 8'h3D || c == 8'h21) begin
					mode_n   = (c == 8'h3D) ? MODE_ASSIGN : MODE_BANG;
					tstart_n = cur_off;
					run_n    = 17'd1;
				end else if (pk_ok) begin
					svld = 1'b1;
					sres = mk_res(pk, line_q, cur_off, 17'd1, 1'b0, 1'b0);
				end else begin
					svld     = 1'b1;
					halted_n = 1'b1;
				end
			end
		end
	end

	assign push.vld0 = fvld || svld;
	assign push.vld1 = fvld && svld;
	assign push.res0 = fvld ? fres : sres;
	assign push.res1 = sres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			prefix_q <= '0;
			run_q    <= '0;
			tstart_q <= '0;
			pos_q    <= '0;
			line_q   <= 16'd1;
			halted_q <= 1'b0;
		end else begin
			mode_q   <= mode_n;
			prefix_q <= prefix_n;
			run_q    <= run_n;
			tstart_q <= tstart_n;
			pos_q    <= pos_n;
			line_q   <= line_n;
			halted_q <= halted_n;
		end
	end

`ifndef SYNTHESIS
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && halted_q && !item.end_of_text |-> !push.vld0)
		else $error("halted scanner produced a result");
	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		push.vld1 |-> !push.res0.last)
		else $error("end marker not in final slot");
	a_eot_reset: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.end_of_text |=> mode_q == MODE_IDLE && line_q == 16'd1 && pos_q == 17'd0)
		else $error("scanner state not cleared after end of text");
`endif

endmodule
`default_nettype wire

[src/mmt_outq.sv]
// Four-entry result queue: takes up to two results a cycle, hands out one.
`default_nettype none
module mmt_outq import mmt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire push_t   push,
	output logic         room,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_item
);

	result_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                pop;
	logic [QPTR_W-1:0]   wr_p1;

	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	// leave space for a two-result word
	assign room      = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign wr_p1     = wr_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.vld0)
			mem_q[wr_q] <= push.res0;
		if (push.vld1)
			mem_q[wr_p1] <= push.res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.vld0) + QPTR_W'(push.vld1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push.vld0) + QCNT_W'(push.vld1) - QCNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.vld0 |-> cnt_q <= QCNT_W'(QDEPTH - 2))
		else $error("result queue pushed without room");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue count out of range");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.vld1 |-> push.vld0)
		else $error("second result pushed without first");
`endif

endmodule
`default_nettype wire

[src/maximal_munch_tokenizer_top.sv]
// Top level of the longest-match tokenizer: input register, scanner, result queue.
`default_nettype none
// Takes one text word per cycle (a byte, or an end-of-text mark) and emits
// tokens by longest match with one byte of lookahead. A word is held in the
// input register, decided combinationally by the scanner, and its results
// (zero, one or two) are written to a four-entry queue that drives the output
// port, one result per cycle while out_ready is high. A word that closes a
// pending token and also yields one of its own produces two results, which the
// output side hands out one after the other; the input side keeps taking one
// word per cycle as long as the queue holds at most two results. Each result is
// registered in the queue before it shows on out_valid. After end of text the
// scanner is back at line 1, offset 0.
module maximal_munch_tokenizer_top import mmt_pkg::*; #(
	parameter int unsigned MAX_TEXT = 65536
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	output logic          out_valid,
	input  wire logic     out_ready,
	output result_t       out_item
);

	in_item_t item_s1;
	logic     valid_s1;
	logic     room;
	logic     fire;
	push_t    push;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	mmt_scan #(
		.MAX_TEXT(MAX_TEXT)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.push  (push)
	);

	mmt_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule
`default_nettype wire
